// ===== hw/rtl/dcf_pkg.sv =====
`timescale 1ns / 1ps

package dcf_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELL_CAPACITY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_RATING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PARALLEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_THRESHOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_TIMEOUT = 3'd4;

    // Register reset values
    localparam logic [15:0]        RST_CELL_CAPACITY     = 16'd0;
    localparam logic [15:0]        RST_DISCHARGE_RATING  = 16'd0;
    localparam logic [7:0]         RST_CELLS_PARALLEL    = 8'd1;
    localparam logic signed [15:0] RST_FAN_THRESHOLD     = 16'sd0;
    localparam logic [31:0]        RST_HEARTBEAT_TIMEOUT = 32'd1000;

    // Limit is product / 10; compared as 10 * current against the product
    localparam logic [3:0] LIMIT_DIVISOR = 4'd10;
    localparam int CUR_SCALED_W = 36;
    localparam int PRODUCT_W    = 40;

    // Discharge phases
    localparam logic [1:0] PH_OFF  = 2'd0;
    localparam logic [1:0] PH_INIT = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Over-current report codes
    localparam logic [1:0] OC_NONE   = 2'd0;
    localparam logic [1:0] OC_ASSERT = 2'd1;
    localparam logic [1:0] OC_PASS   = 2'd2;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_EVAL = 2'd3;

    typedef struct packed {
        logic              discharge_requested;
        logic              contactors_are_closed;
        logic [31:0]       pack_current;
        logic signed [15:0] hottest_cell_temp;
        logic [31:0]       now_ms;
        logic [31:0]       last_message_ms;
    } in_t;

    typedef struct packed {
        logic       close_command;
        logic [1:0] overcurrent_action;
        logic       fans_enable;
        logic       heartbeat_lost;
        logic [1:0] current_state;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul_first;
        logic mul_second;
        logic commit;
    } cmd_t;

endpackage

// ===== hw/rtl/dcf_ctrl.sv =====
`timescale 1ns / 1ps

module dcf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output dcf_pkg::cmd_t cmd
);

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == dcf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Issue datapath commands per state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.load       = 1'b0;
        unique case (state_reg)
            dcf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dcf_pkg::ST_MUL1;
                end
            end
            dcf_pkg::ST_MUL1:
            begin
                cmd.mul_first = 1'b1;
                state_next    = dcf_pkg::ST_MUL2;
            end
            dcf_pkg::ST_MUL2:
            begin
                cmd.mul_second = 1'b1;
                state_next     = dcf_pkg::ST_EVAL;
            end
            dcf_pkg::ST_EVAL:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = dcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcf_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/dcf_datapath.sv =====
`timescale 1ns / 1ps

module dcf_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  dcf_pkg::in_t                    in_data,
    input  dcf_pkg::cmd_t                   cmd,
    output dcf_pkg::out_t                   out_data
);

    // Configuration registers
    logic [15:0]        cell_capacity_reg;
    logic [15:0]        discharge_rating_reg;
    logic [7:0]         cells_parallel_reg;
    logic signed [15:0] fan_threshold_reg;
    logic [31:0]        heartbeat_timeout_reg;

    // Algorithm state
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       fans_reg;
    logic       fans_next;

    // Item and arithmetic registers
    dcf_pkg::in_t                    item_reg;
    logic [31:0]                     prod_first_reg;
    logic [dcf_pkg::PRODUCT_W-1:0]   product_reg;
    dcf_pkg::out_t                   out_reg;
    dcf_pkg::out_t                   out_next;

    logic [dcf_pkg::CUR_SCALED_W-1:0] cur_scaled;
    logic                             over_limit;
    logic [31:0]                      elapsed;
    logic                             hb_lost;
    logic                             fan_hot;
    logic [1:0]                       ph_req;
    logic                             do_run;

    assign out_data = out_reg;

    // Take configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_capacity_reg     <= dcf_pkg::RST_CELL_CAPACITY;
            discharge_rating_reg  <= dcf_pkg::RST_DISCHARGE_RATING;
            cells_parallel_reg    <= dcf_pkg::RST_CELLS_PARALLEL;
            fan_threshold_reg     <= dcf_pkg::RST_FAN_THRESHOLD;
            heartbeat_timeout_reg <= dcf_pkg::RST_HEARTBEAT_TIMEOUT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dcf_pkg::REG_CELL_CAPACITY:     cell_capacity_reg     <= cfg_data[15:0];
                dcf_pkg::REG_DISCHARGE_RATING:  discharge_rating_reg  <= cfg_data[15:0];
                dcf_pkg::REG_CELLS_PARALLEL:    cells_parallel_reg    <= cfg_data[7:0];
                dcf_pkg::REG_FAN_THRESHOLD:     fan_threshold_reg     <= $signed(cfg_data[15:0]);
                dcf_pkg::REG_HEARTBEAT_TIMEOUT: heartbeat_timeout_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Capture the item, run the two multiply steps and register the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.mul_first)
        begin
            prod_first_reg <= {16'd0, cell_capacity_reg} * {16'd0, discharge_rating_reg};
        end
        if (cmd.mul_second)
        begin
            product_reg <= {8'd0, prod_first_reg} * {32'd0, cells_parallel_reg};
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    // Checks: 10 * current above the product means current above the limit
    assign cur_scaled = dcf_pkg::CUR_SCALED_W'(item_reg.pack_current)
                        * dcf_pkg::CUR_SCALED_W'(dcf_pkg::LIMIT_DIVISOR);
    assign over_limit = {{(dcf_pkg::PRODUCT_W - dcf_pkg::CUR_SCALED_W){1'b0}}, cur_scaled}
                        > product_reg;
    assign elapsed    = item_reg.now_ms - item_reg.last_message_ms;
    assign hb_lost    = (item_reg.last_message_ms != 32'd0)
                        && (elapsed > heartbeat_timeout_reg);
    assign fan_hot    = $signed(item_reg.hottest_cell_temp) > fan_threshold_reg;

    // Advance the phase and build the result
    always_comb
    begin
        if (item_reg.discharge_requested)
        begin
            ph_req = (phase_reg == dcf_pkg::PH_OFF) ? dcf_pkg::PH_INIT : phase_reg;
        end
        else
        begin
            ph_req = (phase_reg == dcf_pkg::PH_OFF) ? dcf_pkg::PH_OFF : dcf_pkg::PH_DONE;
        end

        phase_next = ph_req;
        do_run     = 1'b0;
        out_next   = '0;
        unique case (ph_req)
            dcf_pkg::PH_OFF:
            begin
                out_next.close_command = 1'b0;
            end
            dcf_pkg::PH_INIT:
            begin
                out_next.close_command = 1'b1;
                if (item_reg.contactors_are_closed)
                begin
                    phase_next = dcf_pkg::PH_RUN;
                    do_run     = 1'b1;
                end
            end
            dcf_pkg::PH_RUN:
            begin
                out_next.close_command = 1'b1;
                do_run                 = 1'b1;
            end
            default:
            begin
                out_next.close_command = 1'b0;
                if (!item_reg.contactors_are_closed)
                begin
                    phase_next = dcf_pkg::PH_OFF;
                end
            end
        endcase

        fans_next = fans_reg;
        if (do_run)
        begin
            out_next.overcurrent_action = over_limit ? dcf_pkg::OC_ASSERT : dcf_pkg::OC_PASS;
            out_next.heartbeat_lost     = hb_lost;
            fans_next                   = fan_hot;
            if (!item_reg.contactors_are_closed)
            begin
                phase_next = dcf_pkg::PH_INIT;
            end
        end
        else
        begin
            out_next.overcurrent_action = dcf_pkg::OC_NONE;
            out_next.heartbeat_lost     = 1'b0;
        end
        out_next.fans_enable   = fans_next;
        out_next.current_state = phase_next;
    end

    // Commit the step state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dcf_pkg::PH_OFF;
            fans_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            phase_reg <= phase_next;
            fans_reg  <= fans_next;
        end
    end

endmodule

// ===== hw/rtl/discharge_contactor_fsm.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   in_data   (dcf_pkg::in_t)
// out       output     out_valid/out_ready out_data  (dcf_pkg::out_t)
// cfg       input      cfg_write           cfg_index, cfg_data
//
// Each step runs in order: capture, capacity times rating, times cells in
// parallel, then the limit, fan and heartbeat checks with the phase update.
// The multiply is split in two steps; one step is in flight at a time.
// The result register holds a beat while out_ready is low; the next step is
// taken meanwhile and waits in its check cycle until the register frees.
// Reset clears the phase, the fan state and loads register defaults.

module discharge_contactor_fsm (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dcf_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dcf_pkg::out_t                   out_data
);

    dcf_pkg::cmd_t cmd;

    dcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    dcf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_data  (out_data)
    );

endmodule

// ===== dv/discharge_result_check.sv =====
`timescale 1ns / 1ps

module discharge_result_check
    import dcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_t                  out_data,
    output int                    fail_count,
    output int                    waiting,
    output int                    reports_checked
);

    // Local copy of the register file
    logic [15:0]        capacity_cah;
    logic [15:0]        rating_hundredths;
    logic [7:0]         parallel_cells;
    logic signed [15:0] fan_on_temp;
    logic [31:0]        heartbeat_ms;

    // Sequencer state as the block should hold it
    logic [1:0] phase;
    logic       fans_held;

    out_t expected_reports[$];

    initial
    begin
        fail_count      = 0;
        waiting         = 0;
        reports_checked = 0;
    end

    // Advance the sequencer by one beat and return the report it should produce
    function automatic out_t advance_sequencer(input in_t beat);
        out_t        rep;
        logic [63:0] product;
        logic [63:0] limit;
        logic [63:0] wide_cap;
        logic [31:0] since_msg;
        logic        checks;
        rep    = '0;
        checks = 1'b0;

        // Requests first: discharge wakes off, anything else shuts down
        if (beat.discharge_requested)
        begin
            if (phase == PH_OFF)
            begin
                phase = PH_INIT;
            end
        end
        else if (phase != PH_OFF)
        begin
            phase = PH_DONE;
        end

        case (phase)
            PH_OFF:
            begin
                rep.close_command = 1'b0;
            end
            PH_INIT:
            begin
                rep.close_command = 1'b1;
                if (beat.contactors_are_closed)
                begin
                    phase  = PH_RUN;
                    checks = 1'b1;
                end
            end
            PH_RUN:
            begin
                rep.close_command = 1'b1;
                checks            = 1'b1;
            end
            default:
            begin
                rep.close_command = 1'b0;
                if (!beat.contactors_are_closed)
                begin
                    phase = PH_OFF;
                end
            end
        endcase

        // Run checks: over-current, fans, heartbeat; fall back if contactors open
        rep.overcurrent_action = OC_NONE;
        rep.heartbeat_lost     = 1'b0;
        if (checks)
        begin
            wide_cap = {48'b0, capacity_cah};
            product  = wide_cap * {48'b0, rating_hundredths} * {56'b0, parallel_cells};
            limit    = product / LIMIT_DIVISOR;
            rep.overcurrent_action = ({32'b0, beat.pack_current} > limit) ? OC_ASSERT
                                                                           : OC_PASS;
            if (!beat.contactors_are_closed)
            begin
                phase = PH_INIT;
            end
            fans_held = ($signed(beat.hottest_cell_temp) > fan_on_temp);
            since_msg = beat.now_ms - beat.last_message_ms;
            rep.heartbeat_lost = (beat.last_message_ms != 32'd0) && (since_msg > heartbeat_ms);
        end

        rep.fans_enable   = fans_held;
        rep.current_state = phase;
        return rep;
    endfunction

    task automatic compare_field(input string name, input logic [1:0] want,
                                 input logic [1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Track register writes, predict on accepted input beats, check output beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t want;
        if (!rst_n)
        begin
            capacity_cah      = RST_CELL_CAPACITY;
            rating_hundredths = RST_DISCHARGE_RATING;
            parallel_cells    = RST_CELLS_PARALLEL;
            fan_on_temp       = RST_FAN_THRESHOLD;
            heartbeat_ms      = RST_HEARTBEAT_TIMEOUT;
            phase             = PH_OFF;
            fans_held         = 1'b0;
            expected_reports.delete();
            waiting           = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CELL_CAPACITY:     capacity_cah      = cfg_data[15:0];
                    REG_DISCHARGE_RATING:  rating_hundredths = cfg_data[15:0];
                    REG_CELLS_PARALLEL:    parallel_cells    = cfg_data[7:0];
                    REG_FAN_THRESHOLD:     fan_on_temp       = cfg_data[15:0];
                    REG_HEARTBEAT_TIMEOUT: heartbeat_ms      = cfg_data;
                    default:               ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                expected_reports.push_back(advance_sequencer(in_data));
            end

            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected report beat: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("close_command", want.close_command, out_data.close_command);
                    compare_field("overcurrent_action", want.overcurrent_action,
                                  out_data.overcurrent_action);
                    compare_field("fans_enable", want.fans_enable, out_data.fans_enable);
                    compare_field("heartbeat_lost", want.heartbeat_lost, out_data.heartbeat_lost);
                    compare_field("current_state", want.current_state, out_data.current_state);
                    reports_checked++;
                end
            end

            waiting = expected_reports.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dcf_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL    = 80;
    localparam int BLOCK_BEATS   = 105;

    typedef enum int {SET_TYPICAL, SET_MAX, SET_MIN} setting_e;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;

    int fail_count;
    int waiting;
    int reports_checked;

    int send_idle_pct  = 6;
    int recv_idle_pct  = 52;
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;
    int cycles         = 0;
    int beats_sent     = 0;
    int settings_done  = 0;

    // Rough aim points for the stimulus, following what was last written
    logic [63:0] limit_aim = '0;
    logic [15:0] thr_aim   = RST_FAN_THRESHOLD;
    logic [31:0] hb_aim    = RST_HEARTBEAT_TIMEOUT;

    discharge_contactor_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    discharge_result_check result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .fail_count      (fail_count),
        .waiting         (waiting),
        .reports_checked (reports_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL discharge_contactor_fsm");
            $finish;
        end
    end

    // Output side: random back-pressure, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_served != stall_requests)
        begin
            out_ready    <= 1'b0;
            stall_served <= stall_requests;
            stall_left   <= LONG_STALL - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_t make_beat(input logic req, input logic closed,
                                      input logic [31:0] current, input logic [15:0] temp,
                                      input logic [31:0] now, input logic [31:0] last);
        in_t b;
        b.discharge_requested   = req;
        b.contactors_are_closed = closed;
        b.pack_current          = current;
        b.hottest_cell_temp     = temp;
        b.now_ms                = now;
        b.last_message_ms       = last;
        return b;
    endfunction

    // Random content aimed at the limit, the fan threshold and the timeout edge
    function automatic in_t random_beat(input logic req, input logic closed);
        in_t b;
        b.discharge_requested   = req;
        b.contactors_are_closed = closed;
        case ($urandom_range(5))
            0:       b.pack_current = '0;
            1:       b.pack_current = '1;
            2, 3:    b.pack_current = limit_aim[31:0] + $urandom_range(4) - 2;
            default: b.pack_current = $urandom;
        endcase
        case ($urandom_range(4))
            0, 1:    b.hottest_cell_temp = thr_aim + $urandom_range(4) - 2;
            2:       b.hottest_cell_temp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: b.hottest_cell_temp = $urandom;
        endcase
        b.now_ms = $urandom;
        case ($urandom_range(4))
            0:       b.last_message_ms = '0;
            1, 2:    b.last_message_ms = b.now_ms - hb_aim + $urandom_range(4) - 2;
            3:       b.last_message_ms = b.now_ms - $urandom_range(2000);
            default: b.last_message_ms = $urandom;
        endcase
        return b;
    endfunction

    // Offer one beat, with a random gap first, and hold it until accepted
    task automatic send_beat(input in_t beat);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // Drop the input and wait for every outstanding report
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drain, then load a full register setting (junk in the unused upper bits)
    task automatic apply_setting(input setting_e kind);
        logic [15:0] cap;
        logic [15:0] rating;
        logic [7:0]  par;
        logic [15:0] thr;
        logic [31:0] hb;
        logic [31:0] junk;
        logic [63:0] wide_cap;
        case (kind)
            SET_MAX:
            begin
                cap    = '1;
                rating = '1;
                par    = '1;
                thr    = 16'h7FFF;
                hb     = '1;
            end
            SET_MIN:
            begin
                cap    = '0;
                rating = '0;
                par    = '0;
                thr    = 16'h8000;
                hb     = '0;
            end
            default:
            begin
                cap    = $urandom_range(65535);
                rating = $urandom_range($urandom_range(1) ? 200 : 65535);
                par    = $urandom_range(255);
                thr    = $urandom;
                hb     = $urandom_range(1) ? $urandom_range(5000) : $urandom;
            end
        endcase

        drain_results();
        junk = $urandom;
        write_reg(REG_CELL_CAPACITY, {junk[31:16], cap});
        junk = $urandom;
        write_reg(REG_DISCHARGE_RATING, {junk[31:16], rating});
        junk = $urandom;
        write_reg(REG_CELLS_PARALLEL, {junk[31:8], par});
        junk = $urandom;
        write_reg(REG_FAN_THRESHOLD, {junk[31:16], thr});
        write_reg(REG_HEARTBEAT_TIMEOUT, hb);
        // Indexes past the register list must be ignored
        for (int i = REG_HEARTBEAT_TIMEOUT + 1; i < 2 ** CFG_IDX_W; i++)
        begin
            write_reg(i, $urandom);
        end

        wide_cap  = {48'b0, cap};
        limit_aim = wide_cap * {48'b0, rating} * {56'b0, par} / LIMIT_DIVISOR;
        thr_aim   = thr;
        hb_aim    = hb;
        settings_done++;
    endtask

    // Walk the phase transitions and the edges of each check
    task automatic run_directed();
        send_beat(make_beat(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b1, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b1, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0));
        // init passes straight to run once closed
        send_beat(make_beat(1'b1, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b1, 1'b1, 32'd1, 16'd1, 32'd1006, 32'd5));
        send_beat(make_beat(1'b1, 1'b1, '1, 16'h7FFF, 32'd1005, 32'd5));
        // heartbeat across the 32-bit wrap
        send_beat(make_beat(1'b1, 1'b1, 32'd0, 16'h8000, 32'd500, 32'hFFFF_FC00));
        send_beat(make_beat(1'b1, 1'b1, 32'd0, 16'd0, 32'd20, 32'hFFFF_FFF0));
        // contactors open during run: checks still done, back to init
        send_beat(make_beat(1'b1, 1'b0, 32'd7, 16'd3, 32'd9, 32'd9));
        send_beat(make_beat(1'b1, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b0, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b0, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0));
        // a discharge request does not lift done
        send_beat(make_beat(1'b1, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b1, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b1, 1'b1, '1, 16'h8000, 32'd0, 32'd0));
        // run to done to off in one step when contactors already open
        send_beat(make_beat(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0));

        apply_setting(SET_MAX);
        send_beat(make_beat(1'b1, 1'b1, '1, 16'h7FFF, '1, 32'd1));
        send_beat(make_beat(1'b1, 1'b1, '1, 16'h7FFE, 32'd0, '1));

        apply_setting(SET_MIN);
        send_beat(make_beat(1'b1, 1'b1, 32'd0, 16'h8000, 32'd7, 32'd7));
        send_beat(make_beat(1'b1, 1'b1, 32'd1, 16'h8001, 32'd8, 32'd7));
        send_beat(make_beat(1'b1, 1'b1, 32'd5, 16'd0, 32'd0, 32'd0));
        send_beat(make_beat(1'b0, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0));
    endtask

    // Mostly well-formed discharge and shutdown sequences, some noise
    task automatic run_random_block(input int count);
        int   sent;
        int   seg_kind;
        int   seg_len;
        logic req;
        logic closed;
        sent = 0;
        while (sent < count)
        begin
            seg_kind = $urandom_range(9);
            seg_len  = $urandom_range(1, 12);
            for (int k = 0; k < seg_len && sent < count; k++)
            begin
                if (seg_kind <= 5)
                begin
                    req    = 1'b1;
                    closed = ($urandom_range(9) != 0);
                end
                else if (seg_kind <= 7)
                begin
                    req    = 1'b0;
                    closed = $urandom_range(1);
                end
                else
                begin
                    req    = $urandom_range(1);
                    closed = $urandom_range(1);
                end
                send_beat(random_beat(req, closed));
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        setting_e kind;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Three idle mixes: slow receiver, slow sender, then none
        for (int regime = 0; regime < 3; regime++)
        begin
            for (int blk = 0; blk < 3; blk++)
            begin
                if (blk == 2)
                begin
                    kind = regime[0] ? SET_MIN : SET_MAX;
                end
                else
                begin
                    kind = SET_TYPICAL;
                end
                apply_setting(kind);
                @(posedge clk);
                send_idle_pct = (regime == 0) ? 6 : (regime == 1) ? 52 : 0;
                recv_idle_pct = (regime == 0) ? 52 : (regime == 1) ? 6 : 0;
                // Hold the output off while the sender keeps offering beats
                if (regime == 2 && blk == 1)
                begin
                    stall_requests++;
                end
                run_random_block(BLOCK_BEATS);
            end
        end

        drain_results();
        $display("Sent %0d input beats over %0d register settings and three idle mixes,",
                 beats_sent, settings_done);
        $display("including a long output hold-off; %0d reports compared.", reports_checked);
        if (fail_count == 0 && waiting == 0)
        begin
            $display("PASS discharge_contactor_fsm");
        end
        else
        begin
            $display("FAIL discharge_contactor_fsm");
        end
        $finish;
    end

endmodule
